// ===== rtl/csr_row_gather_top_macros.svh =====
// ---------------------------------------------------------------------------
// csr row gather assertion macros
// shared property forms for the row gather checks
// ---------------------------------------------------------------------------
`ifndef CSR_ROW_GATHER_TOP_MACROS_SVH
`define CSR_ROW_GATHER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CRG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csr row gather check failed");

// next-cycle implication, checked outside reset
`define CRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csr row gather check failed");

`endif

// ===== rtl/csr_rg_pkg.sv =====
// ---------------------------------------------------------------------------
// csr row gather package
// sizes, operation and status codes and port bundles of the row gather
// ---------------------------------------------------------------------------
package csr_rg_pkg;

   localparam int ROW_DEPTH     = 256;
   localparam int NONZERO_DEPTH = 1024;
   localparam int MAX_COLS      = 32;

   localparam int OP_W    = 2;
   localparam int ADDR_W  = 11;
   localparam int PTR_W   = 11;
   localparam int VALUE_W = 64;
   localparam int COL_W   = 5;
   localparam int ROW_W   = 8;
   localparam int POS_W   = 32;
   localparam int STAT_W  = 2;

   localparam int RP_DEPTH  = ROW_DEPTH + 1;
   localparam int RP_ADDR_W = $clog2(RP_DEPTH);
   localparam int NZ_ADDR_W = $clog2(NONZERO_DEPTH);
   localparam int NZ_W      = VALUE_W + COL_W;
   localparam int CNT_W     = $clog2(MAX_COLS + 1);

   // operations
   localparam logic [OP_W-1:0] OP_LOAD_PTR = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_NZ  = 2'd1;
   localparam logic [OP_W-1:0] OP_START    = 2'd2;
   localparam logic [OP_W-1:0] OP_ROW      = 2'd3;

   // result kinds
   localparam logic KIND_NONZERO = 1'b0;
   localparam logic KIND_POINTER = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ROW_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EXTENT    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_SATURATED = 2'd3;

   // row pointer memory access
   typedef struct packed {
      logic                 we;
      logic [RP_ADDR_W-1:0] addr;
      logic [PTR_W-1:0]     wdata;
   } rp_port_type;

   // nonzero memory access, value and column side by side
   typedef struct packed {
      logic                 we;
      logic [NZ_ADDR_W-1:0] addr;
      logic [NZ_W-1:0]      wdata;
   } nz_port_type;

   // one result beat
   typedef struct packed {
      logic              valid;
      logic              kind;
      logic [VALUE_W-1:0] value_bits;
      logic [COL_W-1:0]  column;
      logic [POS_W-1:0]  position;
      logic [STAT_W-1:0] status;
      logic              last;
   } rsp_type;

endpackage

// ===== rtl/csr_row_gather_top.sv =====
// a load gives no beat; start and an out-of-range row give their beat in the cycle after
// acceptance; a bad extent gives its beat once both row pointers have been read
// a row of n nonzeros keeps busy high through two row pointer reads, one nonzero read a
// cycle and one closing beat; results cannot be stalled; synchronous active-high reset
// clears the sequencer, the running count and the result strobe, memories hold undefined
// data until written
// ---------------------------------------------------------------------------
// csr row gather top level
// sparse matrix row slicer over a row pointer memory and a nonzero memory
// ---------------------------------------------------------------------------
`include "csr_row_gather_top_macros.svh"

module csr_row_gather_top (
   input  logic                               clock,
   input  logic                               reset,
   // command side, a beat is taken when start is high and busy is low
   input  logic                               start,
   output logic                               busy,
   input  logic [csr_rg_pkg::OP_W-1:0]        req_operation,
   input  logic [csr_rg_pkg::ADDR_W-1:0]      req_address,
   input  logic [csr_rg_pkg::PTR_W-1:0]       req_pointer_value,
   input  logic [csr_rg_pkg::VALUE_W-1:0]     req_value_bits,
   input  logic [csr_rg_pkg::COL_W-1:0]       req_column,
   input  logic [csr_rg_pkg::ROW_W-1:0]       req_row,
   // result side, one beat per cycle of rsp_valid
   output logic                               rsp_valid,
   output logic                               rsp_kind,
   output logic [csr_rg_pkg::VALUE_W-1:0]     rsp_out_value_bits,
   output logic [csr_rg_pkg::COL_W-1:0]       rsp_out_column,
   output logic [csr_rg_pkg::POS_W-1:0]       rsp_position,
   output logic [csr_rg_pkg::STAT_W-1:0]      rsp_status,
   output logic                               rsp_last
);

   // memory access bundles from the sequencer
   csr_rg_pkg::rp_port_type          rp_port;
   csr_rg_pkg::nz_port_type          nz_port;
   logic [csr_rg_pkg::PTR_W-1:0]     rp_rdata;
   logic [csr_rg_pkg::NZ_W-1:0]      nz_rdata;
   csr_rg_pkg::rsp_type              rsp;

   // row pointer table, row r spans slots [ptr(r), ptr(r+1))
   csr_rg_ram #(
      .WIDTH (csr_rg_pkg::PTR_W),
      .DEPTH (csr_rg_pkg::RP_DEPTH)
   ) u_rp_ram (
      .clock (clock),
      .we    (rp_port.we),
      .addr  (rp_port.addr),
      .wdata (rp_port.wdata),
      .rdata (rp_rdata)
   );

   // nonzero store, value bits above column
   csr_rg_ram #(
      .WIDTH (csr_rg_pkg::NZ_W),
      .DEPTH (csr_rg_pkg::NONZERO_DEPTH)
   ) u_nz_ram (
      .clock (clock),
      .we    (nz_port.we),
      .addr  (nz_port.addr),
      .wdata (nz_port.wdata),
      .rdata (nz_rdata)
   );

   // command decode, extent walk and result forming; loads write at the
   // accepting edge and any later read sees them, so no forwarding is needed
   csr_rg_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_address       (req_address),
      .req_pointer_value (req_pointer_value),
      .req_value_bits    (req_value_bits),
      .req_column        (req_column),
      .req_row           (req_row),
      .rp_port           (rp_port),
      .rp_rdata          (rp_rdata),
      .nz_port           (nz_port),
      .nz_rdata          (nz_rdata),
      .rsp               (rsp)
   );

   assign rsp_valid          = rsp.valid;
   assign rsp_kind           = rsp.kind;
   assign rsp_out_value_bits = rsp.value_bits;
   assign rsp_out_column     = rsp.column;
   assign rsp_position       = rsp.position;
   assign rsp_status         = rsp.status;
   assign rsp_last           = rsp.last;

   // a beat shown while idle closes its command
   `CRG_ASSERT_IMPLY(a_idle_beat_last, clock, reset, rsp_valid && !busy, rsp_last)

   // nonzero beats come only mid-walk, clean and never last
   `CRG_ASSERT_IMPLY(a_nz_beat_form, clock, reset,
      rsp_valid && (rsp_kind == csr_rg_pkg::KIND_NONZERO),
      busy && !rsp_last && (rsp_status == csr_rg_pkg::STAT_OK))

   // start answers next cycle with pointer zero
   `CRG_ASSERT_NEXT(a_start_beat, clock, reset,
      start && !busy && (req_operation == csr_rg_pkg::OP_START),
      rsp_valid && rsp_last && (rsp_kind == csr_rg_pkg::KIND_POINTER)
      && (rsp_position == '0))

   // loads never raise busy or a beat
   `CRG_ASSERT_NEXT(a_load_silent, clock, reset,
      start && !busy && ((req_operation == csr_rg_pkg::OP_LOAD_PTR)
      || (req_operation == csr_rg_pkg::OP_LOAD_NZ)),
      !busy && !rsp_valid)

endmodule

// ===== rtl/csr_rg_ram.sv =====
// ---------------------------------------------------------------------------
// csr row gather ram
// single-port synchronous ram, one read or write a cycle, registered read
// ---------------------------------------------------------------------------
module csr_rg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/csr_rg_seq.sv =====
// ---------------------------------------------------------------------------
// csr row gather sequencer
// decodes commands, walks row extents through the memories, forms results
// ---------------------------------------------------------------------------
module csr_rg_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [csr_rg_pkg::OP_W-1:0]         req_operation,
   input  logic [csr_rg_pkg::ADDR_W-1:0]       req_address,
   input  logic [csr_rg_pkg::PTR_W-1:0]        req_pointer_value,
   input  logic [csr_rg_pkg::VALUE_W-1:0]      req_value_bits,
   input  logic [csr_rg_pkg::COL_W-1:0]        req_column,
   input  logic [csr_rg_pkg::ROW_W-1:0]        req_row,
   output csr_rg_pkg::rp_port_type             rp_port,
   input  logic [csr_rg_pkg::PTR_W-1:0]        rp_rdata,
   output csr_rg_pkg::nz_port_type             nz_port,
   input  logic [csr_rg_pkg::NZ_W-1:0]         nz_rdata,
   output csr_rg_pkg::rsp_type                 rsp
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LO   = 3'd1;
   localparam logic [2:0] ST_HI   = 3'd2;
   localparam logic [2:0] ST_WALK = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam int PW = csr_rg_pkg::POS_W;

   logic [2:0]                          state_ff, state_in;
   logic [PW-1:0]                       count_ff, count_in;
   logic [csr_rg_pkg::RP_ADDR_W-1:0]    row_ff, row_in;
   logic [csr_rg_pkg::PTR_W-1:0]        start_ff, start_in;
   logic [csr_rg_pkg::PTR_W-1:0]        slot_ff, slot_in;
   logic [csr_rg_pkg::CNT_W-1:0]        n_ff, n_in;
   logic [csr_rg_pkg::CNT_W-1:0]        idx_ff, idx_in;
   csr_rg_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                                accept;
   logic [csr_rg_pkg::RP_ADDR_W-1:0]    req_row_ext;
   logic [csr_rg_pkg::PTR_W-1:0]        extent;
   logic                                bad_extent;
   logic [PW:0]                         slot_sum;
   logic [PW:0]                         total_sum;

   assign accept      = start && (state_ff == ST_IDLE);
   assign req_row_ext = csr_rg_pkg::RP_ADDR_W'(req_row);
   assign extent      = rp_rdata - start_ff;
   assign bad_extent  = (rp_rdata < start_ff)
                     || (extent > csr_rg_pkg::PTR_W'(csr_rg_pkg::MAX_COLS))
                     || (rp_rdata > csr_rg_pkg::PTR_W'(csr_rg_pkg::NONZERO_DEPTH));
   assign slot_sum    = {1'b0, count_ff} + (PW+1)'(idx_ff);
   assign total_sum   = {1'b0, count_ff} + (PW+1)'(n_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      row_in   = row_ff;
      start_in = start_ff;
      slot_in  = slot_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;

      rsp_in            = rsp_ff;
      rsp_in.valid      = 1'b0;

      rp_port.we    = 1'b0;
      rp_port.addr  = req_address[csr_rg_pkg::RP_ADDR_W-1:0];
      rp_port.wdata = req_pointer_value;

      nz_port.we    = 1'b0;
      nz_port.addr  = req_address[csr_rg_pkg::NZ_ADDR_W-1:0];
      nz_port.wdata = {req_value_bits, req_column};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  csr_rg_pkg::OP_LOAD_PTR: begin
                     rp_port.we = (req_address
                                   <= csr_rg_pkg::ADDR_W'(csr_rg_pkg::ROW_DEPTH));
                  end
                  csr_rg_pkg::OP_LOAD_NZ: begin
                     nz_port.we = (req_address
                                   < csr_rg_pkg::ADDR_W'(csr_rg_pkg::NONZERO_DEPTH));
                  end
                  csr_rg_pkg::OP_START: begin
                     count_in          = '0;
                     rsp_in.valid      = 1'b1;
                     rsp_in.kind       = csr_rg_pkg::KIND_POINTER;
                     rsp_in.value_bits = '0;
                     rsp_in.column     = '0;
                     rsp_in.position   = '0;
                     rsp_in.status     = csr_rg_pkg::STAT_OK;
                     rsp_in.last       = 1'b1;
                  end
                  csr_rg_pkg::OP_ROW: begin
                     if (req_row_ext >= csr_rg_pkg::RP_ADDR_W'(csr_rg_pkg::ROW_DEPTH)) begin
                        rsp_in.valid      = 1'b1;
                        rsp_in.kind       = csr_rg_pkg::KIND_POINTER;
                        rsp_in.value_bits = '0;
                        rsp_in.column     = '0;
                        rsp_in.position   = count_ff;
                        rsp_in.status     = csr_rg_pkg::STAT_ROW_RANGE;
                        rsp_in.last       = 1'b1;
                     end else begin
                        rp_port.addr = req_row_ext;
                        row_in       = req_row_ext;
                        state_in     = ST_LO;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LO: begin
            // row start arrives, fetch the row end
            start_in     = rp_rdata;
            rp_port.addr = row_ff + csr_rg_pkg::RP_ADDR_W'(1);
            state_in     = ST_HI;
         end
         ST_HI: begin
            if (bad_extent) begin
               rsp_in.valid      = 1'b1;
               rsp_in.kind       = csr_rg_pkg::KIND_POINTER;
               rsp_in.value_bits = '0;
               rsp_in.column     = '0;
               rsp_in.position   = count_ff;
               rsp_in.status     = csr_rg_pkg::STAT_EXTENT;
               rsp_in.last       = 1'b1;
               state_in          = ST_IDLE;
            end else begin
               n_in         = extent[csr_rg_pkg::CNT_W-1:0];
               idx_in       = '0;
               nz_port.addr = start_ff[csr_rg_pkg::NZ_ADDR_W-1:0];
               slot_in      = start_ff + csr_rg_pkg::PTR_W'(1);
               state_in     = (extent == '0) ? ST_FIN : ST_WALK;
            end
         end
         ST_WALK: begin
            rsp_in.valid      = 1'b1;
            rsp_in.kind       = csr_rg_pkg::KIND_NONZERO;
            rsp_in.value_bits = nz_rdata[csr_rg_pkg::NZ_W-1:csr_rg_pkg::COL_W];
            rsp_in.column     = nz_rdata[csr_rg_pkg::COL_W-1:0];
            rsp_in.position   = slot_sum[PW] ? '1 : slot_sum[PW-1:0];
            rsp_in.status     = csr_rg_pkg::STAT_OK;
            rsp_in.last       = 1'b0;
            nz_port.addr      = slot_ff[csr_rg_pkg::NZ_ADDR_W-1:0];
            slot_in           = slot_ff + csr_rg_pkg::PTR_W'(1);
            idx_in            = idx_ff + csr_rg_pkg::CNT_W'(1);
            if (idx_ff == n_ff - csr_rg_pkg::CNT_W'(1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            count_in          = total_sum[PW] ? '1 : total_sum[PW-1:0];
            rsp_in.valid      = 1'b1;
            rsp_in.kind       = csr_rg_pkg::KIND_POINTER;
            rsp_in.value_bits = '0;
            rsp_in.column     = '0;
            rsp_in.position   = total_sum[PW] ? '1 : total_sum[PW-1:0];
            rsp_in.status     = total_sum[PW] ? csr_rg_pkg::STAT_SATURATED
                                              : csr_rg_pkg::STAT_OK;
            rsp_in.last       = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      start_ff <= start_in;
      slot_ff  <= slot_in;
      n_ff     <= n_in;
      idx_ff   <= idx_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp  = rsp_ff;

endmodule

// ===== tb/tb_csr_row_gather_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csr row gather testbench
// drives load, start and row commands into the row gather and checks every
// result beat, field by field and in order, against a predictor kept in the
// bench; a short scripted part covers the corner rows, random matrices follow
// ---------------------------------------------------------------------------
module tb_csr_row_gather_top;

   localparam int ITEM_GOAL  = 410;
   localparam int SCRIPT_LEN = 26;
   localparam longint unsigned COUNT_TOP = 64'h0000_0000_FFFF_FFFF;
   localparam int RPA_W = csr_rg_pkg::RP_ADDR_W;
   localparam int NZA_W = csr_rg_pkg::NZ_ADDR_W;

   // one command beat, plus an optional hand-written expectation for the
   // scripted commands whose single pointer beat can be read off directly
   typedef struct packed {
      logic [csr_rg_pkg::OP_W-1:0]    op;
      logic [csr_rg_pkg::ADDR_W-1:0]  addr;
      logic [csr_rg_pkg::PTR_W-1:0]   ptr;
      logic [csr_rg_pkg::VALUE_W-1:0] vbits;
      logic [csr_rg_pkg::COL_W-1:0]   col;
      logic [csr_rg_pkg::ROW_W-1:0]   row;
      logic                           fixed;
      logic [csr_rg_pkg::POS_W-1:0]   fixed_pos;
      logic [csr_rg_pkg::STAT_W-1:0]  fixed_stat;
   } gather_cmd_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [csr_rg_pkg::OP_W-1:0]     req_operation = '0;
   logic [csr_rg_pkg::ADDR_W-1:0]   req_address = '0;
   logic [csr_rg_pkg::PTR_W-1:0]    req_pointer_value = '0;
   logic [csr_rg_pkg::VALUE_W-1:0]  req_value_bits = '0;
   logic [csr_rg_pkg::COL_W-1:0]    req_column = '0;
   logic [csr_rg_pkg::ROW_W-1:0]    req_row = '0;
   logic                            rsp_valid;
   logic                            rsp_kind;
   logic [csr_rg_pkg::VALUE_W-1:0]  rsp_out_value_bits;
   logic [csr_rg_pkg::COL_W-1:0]    rsp_out_column;
   logic [csr_rg_pkg::POS_W-1:0]    rsp_position;
   logic [csr_rg_pkg::STAT_W-1:0]   rsp_status;
   logic                            rsp_last;

   // predictor's copy of the matrix tables and the running output count
   logic [csr_rg_pkg::PTR_W-1:0]    ptr_mem [0:csr_rg_pkg::RP_DEPTH-1];
   logic [csr_rg_pkg::VALUE_W-1:0]  val_mem [0:csr_rg_pkg::NONZERO_DEPTH-1];
   logic [csr_rg_pkg::COL_W-1:0]    col_mem [0:csr_rg_pkg::NONZERO_DEPTH-1];
   bit                              ptr_seen [0:csr_rg_pkg::RP_DEPTH-1];
   bit                              nz_seen [0:csr_rg_pkg::NONZERO_DEPTH-1];
   logic [csr_rg_pkg::POS_W-1:0]    slice_count = '0;

   csr_rg_pkg::rsp_type step_beats [$];   // beats caused by the command just taken
   csr_rg_pkg::rsp_type owed_beats [$];   // beats still to come out of the block
   int                  work_items = 0;
   int                  fault_count = 0;

   csr_row_gather_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_address        (req_address),
      .req_pointer_value  (req_pointer_value),
      .req_value_bits     (req_value_bits),
      .req_column         (req_column),
      .req_row            (req_row),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_out_value_bits (rsp_out_value_bits),
      .rsp_out_column     (rsp_out_column),
      .rsp_position       (rsp_position),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // scripted part: empty and full-valued nonzeros, an empty row, the last
   // row pointer slot, the last nonzero slot, loads just out of range, and
   // each way a row extent can be bad (reversed, too long, past the store);
   // the running count is 3 by the time the bad extents come round
   gather_cmd_type script [SCRIPT_LEN] = '{
      '{csr_rg_pkg::OP_START, 0, 0, 64'h0, 0, 0, 1, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_PTR, 0, 0, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_PTR, 1, 2, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_PTR, 2, 2, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_NZ, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 31, 0, 0, 0,
        csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_NZ, 1, 0, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_ROW, 0, 0, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_ROW, 0, 0, 64'h0, 0, 1, 1, 2, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_PTR, 256, 1024, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_PTR, 255, 1024, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_ROW, 0, 0, 64'h0, 0, 255, 1, 2, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_PTR, 257, 2047, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_NZ, 1024, 0, 64'h5A5A_A5A5_0F0F_F0F0, 21, 0, 0, 0,
        csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_NZ, 1023, 0, 64'h8000_0000_0000_0001, 16, 0, 0, 0,
        csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_PTR, 3, 1023, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_PTR, 4, 1024, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_ROW, 0, 0, 64'h0, 0, 3, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_PTR, 5, 10, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_PTR, 6, 9, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_ROW, 0, 0, 64'h0, 0, 5, 1, 3, csr_rg_pkg::STAT_EXTENT},
      '{csr_rg_pkg::OP_LOAD_PTR, 7, 42, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_ROW, 0, 0, 64'h0, 0, 6, 1, 3, csr_rg_pkg::STAT_EXTENT},
      '{csr_rg_pkg::OP_LOAD_PTR, 8, 1020, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_LOAD_PTR, 9, 1030, 64'h0, 0, 0, 0, 0, csr_rg_pkg::STAT_OK},
      '{csr_rg_pkg::OP_ROW, 0, 0, 64'h0, 0, 8, 1, 3, csr_rg_pkg::STAT_EXTENT},
      '{csr_rg_pkg::OP_START, 0, 0, 64'h0, 0, 0, 1, 0, csr_rg_pkg::STAT_OK}
   };

   function automatic logic [csr_rg_pkg::POS_W-1:0] clip_count(
      input longint unsigned sum);
      return (sum > COUNT_TOP) ? csr_rg_pkg::POS_W'(COUNT_TOP) : csr_rg_pkg::POS_W'(sum);
   endfunction

   // closing beat of a command: an output row pointer or an error
   function automatic csr_rg_pkg::rsp_type count_beat(
      input logic [csr_rg_pkg::POS_W-1:0]  pos,
      input logic [csr_rg_pkg::STAT_W-1:0] st);
      csr_rg_pkg::rsp_type b;
      b = '0;
      b.valid    = 1'b1;
      b.kind     = csr_rg_pkg::KIND_POINTER;
      b.position = pos;
      b.status   = st;
      b.last     = 1'b1;
      return b;
   endfunction

   // updates the predictor's tables and fills step_beats; returns 0 for a
   // load whose address is past its table, which the block just drops
   function automatic bit predict_gather(input gather_cmd_type c);
      int unsigned         lo, hi, j;
      longint unsigned     total;
      csr_rg_pkg::rsp_type b;
      step_beats.delete();
      case (c.op)
         csr_rg_pkg::OP_LOAD_PTR: begin
            if (c.addr > csr_rg_pkg::ROW_DEPTH) return 1'b0;
            ptr_mem[RPA_W'(c.addr)]  = c.ptr;
            ptr_seen[RPA_W'(c.addr)] = 1'b1;
         end
         csr_rg_pkg::OP_LOAD_NZ: begin
            if (c.addr >= csr_rg_pkg::NONZERO_DEPTH) return 1'b0;
            val_mem[NZA_W'(c.addr)] = c.vbits;
            col_mem[NZA_W'(c.addr)] = c.col;
            nz_seen[NZA_W'(c.addr)] = 1'b1;
         end
         csr_rg_pkg::OP_START: begin
            slice_count = '0;
            step_beats.push_back(count_beat('0, csr_rg_pkg::STAT_OK));
         end
         default: begin
            // out-of-range rows need row >= 256, which an 8-bit row never is
            if (int'(c.row) >= csr_rg_pkg::ROW_DEPTH) begin
               step_beats.push_back(count_beat(slice_count, csr_rg_pkg::STAT_ROW_RANGE));
            end else begin
               lo = 32'(ptr_mem[RPA_W'(c.row)]);
               hi = 32'(ptr_mem[RPA_W'(32'(c.row) + 1)]);
               if (hi < lo || hi - lo > csr_rg_pkg::MAX_COLS ||
                   hi > csr_rg_pkg::NONZERO_DEPTH) begin
                  step_beats.push_back(count_beat(slice_count, csr_rg_pkg::STAT_EXTENT));
               end else begin
                  for (j = lo; j < hi; j++) begin
                     b = '0;
                     b.valid      = 1'b1;
                     b.kind       = csr_rg_pkg::KIND_NONZERO;
                     b.value_bits = val_mem[NZA_W'(j)];
                     b.column     = col_mem[NZA_W'(j)];
                     b.position   = clip_count(64'(slice_count) + 64'(j - lo));
                     b.status     = csr_rg_pkg::STAT_OK;
                     step_beats.push_back(b);
                  end
                  // count holds at all ones and flags once it would pass it
                  total       = 64'(slice_count) + 64'(hi - lo);
                  slice_count = clip_count(total);
                  step_beats.push_back(count_beat(slice_count,
                     (total > COUNT_TOP) ? csr_rg_pkg::STAT_SATURATED
                                         : csr_rg_pkg::STAT_OK));
               end
            end
         end
      endcase
      return 1'b1;
   endfunction

   // a row may be asked for only if it never makes the block read a table
   // entry that has not been written; bad extents stop at the pointer reads
   function automatic bit row_readable(input int unsigned r);
      int unsigned lo, hi, s;
      if (!ptr_seen[RPA_W'(r)] || !ptr_seen[RPA_W'(r + 1)]) return 1'b0;
      lo = 32'(ptr_mem[RPA_W'(r)]);
      hi = 32'(ptr_mem[RPA_W'(r + 1)]);
      if (hi < lo || hi - lo > csr_rg_pkg::MAX_COLS || hi > csr_rg_pkg::NONZERO_DEPTH)
         return 1'b1;
      for (s = lo; s < hi; s++)
         if (!nz_seen[NZA_W'(s)]) return 1'b0;
      return 1'b1;
   endfunction

   // present one command, hold it until taken, then book its beats; start
   // stays high so a back-to-back command costs no dead cycle
   task automatic send(input gather_cmd_type c);
      int unsigned pct;
      req_operation     <= c.op;
      req_address       <= c.addr;
      req_pointer_value <= c.ptr;
      req_value_bits    <= c.vbits;
      req_column        <= c.col;
      req_row           <= c.row;
      start             <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (predict_gather(c)) work_items++;
      if (c.fixed) owed_beats.push_back(count_beat(c.fixed_pos, c.fixed_stat));
      else foreach (step_beats[k]) owed_beats.push_back(step_beats[k]);
      // sender idling per cycle: light at first, heavy next, none at the end
      pct = (work_items < 140) ? 18 : (work_items < 275) ? 59 : 0;
      while ($urandom_range(1, 100) <= pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // hold off until every owed beat has come out
   task automatic drain_beats();
      start <= 1'b0;
      @(posedge clock);
      while (owed_beats.size() != 0) @(posedge clock);
   endtask

   // one well-formed slice: a few neighbouring rows, their pointers, their
   // nonzeros with random content, an optional start, then row requests;
   // now and then a row is 32 long, one too long, or reversed, and rows near
   // the end of the store can run past it
   task automatic run_episode();
      int unsigned    n_rows, row0, pick, span, slot, asks, k;
      logic [2:0]     i, j;
      int unsigned    bounds [0:4];
      bit             downward;
      gather_cmd_type c;
      n_rows = $urandom_range(1, 4);
      row0   = $urandom_range(0, csr_rg_pkg::ROW_DEPTH - n_rows);
      bounds[0] = ($urandom_range(0, 5) == 0)
                  ? $urandom_range(990, csr_rg_pkg::NONZERO_DEPTH)
                  : $urandom_range(0, 960);
      for (i = 3'd0; 32'(i) < n_rows; i++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) span = csr_rg_pkg::MAX_COLS;
         else if (pick == 1) span = csr_rg_pkg::MAX_COLS + 1;
         else span = $urandom_range(0, 6);
         if (pick == 2 && bounds[i] > 0) bounds[i + 3'd1] = bounds[i] - 1;
         else bounds[i + 3'd1] = bounds[i] + span;
      end
      downward = 1'($urandom_range(0, 1));
      for (i = 3'd0; 32'(i) <= n_rows; i++) begin
         j = downward ? 3'(n_rows - 32'(i)) : i;
         c = '0;
         c.op   = csr_rg_pkg::OP_LOAD_PTR;
         c.addr = csr_rg_pkg::ADDR_W'(row0 + 32'(j));
         c.ptr  = csr_rg_pkg::PTR_W'(bounds[j]);
         send(c);
      end
      for (i = 3'd0; 32'(i) < n_rows; i++) begin
         if (bounds[i + 3'd1] >= bounds[i] &&
             bounds[i + 3'd1] - bounds[i] <= csr_rg_pkg::MAX_COLS &&
             bounds[i + 3'd1] <= csr_rg_pkg::NONZERO_DEPTH) begin
            for (slot = bounds[i]; slot < bounds[i + 3'd1]; slot++) begin
               c = '0;
               c.op    = csr_rg_pkg::OP_LOAD_NZ;
               c.addr  = csr_rg_pkg::ADDR_W'(slot);
               c.vbits = {$urandom, $urandom};
               c.col   = csr_rg_pkg::COL_W'($urandom_range(0, 31));
               send(c);
            end
         end
      end
      if ($urandom_range(0, 3) != 0) begin
         c = '0;
         c.op = csr_rg_pkg::OP_START;
         send(c);
      end
      asks = n_rows + $urandom_range(0, 2);
      for (k = 0; k < asks; k++) begin
         c = '0;
         c.op  = csr_rg_pkg::OP_ROW;
         c.row = csr_rg_pkg::ROW_W'(row0 + ((k < n_rows) ? k
                                                         : $urandom_range(0, n_rows - 1)));
         send(c);
      end
   endtask

   // stray commands between slices: loads anywhere (out of range too, and
   // ones that break rows already set up), lone starts, requests for rows
   // that are safe to read
   task automatic noise_item();
      gather_cmd_type c;
      int unsigned    tries;
      c = '0;
      case ($urandom_range(0, 3))
         0: begin
            c.op   = csr_rg_pkg::OP_LOAD_PTR;
            c.addr = csr_rg_pkg::ADDR_W'($urandom_range(0, 1)
                        ? $urandom_range(0, csr_rg_pkg::ROW_DEPTH)
                        : $urandom_range(0, 2**csr_rg_pkg::ADDR_W - 1));
            c.ptr  = csr_rg_pkg::PTR_W'($urandom_range(0, 2**csr_rg_pkg::PTR_W - 1));
         end
         1: begin
            c.op    = csr_rg_pkg::OP_LOAD_NZ;
            c.addr  = csr_rg_pkg::ADDR_W'($urandom_range(0, 1)
                         ? $urandom_range(0, csr_rg_pkg::NONZERO_DEPTH - 1)
                         : $urandom_range(0, 2**csr_rg_pkg::ADDR_W - 1));
            c.vbits = {$urandom, $urandom};
            c.col   = csr_rg_pkg::COL_W'($urandom_range(0, 31));
         end
         2: c.op = csr_rg_pkg::OP_START;
         default: begin
            c.op  = csr_rg_pkg::OP_ROW;
            c.row = csr_rg_pkg::ROW_W'($urandom_range(0, 255));
            for (tries = 0; tries < 16 && !row_readable(32'(c.row)); tries++)
               c.row = csr_rg_pkg::ROW_W'($urandom_range(0, 255));
            if (!row_readable(32'(c.row))) return;
         end
      endcase
      send(c);
   endtask

   // result side: each beat is taken at the edge closing its cycle and must
   // match the oldest owed beat
   always @(posedge clock) begin : beat_check
      csr_rg_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (owed_beats.size() == 0) begin
            $error("unexpected beat: kind %0d position %0d status %0d",
                   rsp_kind, rsp_position, rsp_status);
            fault_count++;
         end else begin
            want = owed_beats.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               fault_count++;
            end
            if (rsp_out_value_bits !== want.value_bits) begin
               $error("out_value_bits: expected %h, got %h",
                      want.value_bits, rsp_out_value_bits);
               fault_count++;
            end
            if (rsp_out_column !== want.column) begin
               $error("out_column: expected %0d, got %0d", want.column, rsp_out_column);
               fault_count++;
            end
            if (rsp_position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_position);
               fault_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fault_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               fault_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int i, guard, phase;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < SCRIPT_LEN; i++) send(script[i]);
      drain_beats();

      // mostly whole slices, the rest stray commands; the sender waits for
      // the block to empty at each change of idling pattern
      phase = 0;
      while (work_items < ITEM_GOAL) begin
         if ($urandom_range(0, 9) < 7) run_episode();
         else noise_item();
         if ((phase == 0 && work_items >= 140) || (phase == 1 && work_items >= 275)) begin
            drain_beats();
            phase++;
         end
      end

      start <= 1'b0;
      @(posedge clock);
      for (guard = 0; owed_beats.size() != 0 && guard < 4000; guard++) @(posedge clock);
      // then watch on for longer than a longest row takes
      repeat (40) @(posedge clock);
      if (owed_beats.size() != 0) begin
         $error("%0d expected beats never came out", owed_beats.size());
         fault_count++;
      end
      if (fault_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // backstop well beyond the slowest correct run
   initial begin : watchdog
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
